>>> hdl/mbb_pkg.sv
// shared constants, types and colour conversion for the monochrome bitmap blitter
package mbb_pkg;

    localparam int SCREEN_WIDTH  = 480;
    localparam int SCREEN_HEIGHT = 272;
    localparam int LINE_STRIDE   = 512;
    localparam int MAX_WIDTH     = 1024;

    localparam int WORD_BITS   = 32;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_RECT_WIDTH  = 3'd2,
        REG_RECT_HEIGHT = 3'd3,
        REG_DRAW_COLOR  = 3'd4,
        REG_FILL_MODE   = 3'd5,
        REG_FRAME_BASE  = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } blit_state_t;

    // rgb565 values are widened by replicating the high bits
    function automatic logic [31:0] color_to_rgba(input logic [31:0] v);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        if (v[31:16] == 16'h0000)
        begin
            r = {v[15:11], v[15:13]};
            g = {v[10:5], v[10:9]};
            b = {v[4:0], v[4:2]};
        end
        else
        begin
            r = v[23:16];
            g = v[15:8];
            b = v[7:0];
        end
        return {8'hFF, b, g, r};
    endfunction

endpackage

>>> hdl/mbb_cfg_if.sv
// configuration write channel
interface mbb_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [mbb_pkg::CFG_INDEX_W-1:0]  index;
    logic [31:0]                      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/mbb_word_if.sv
// bitmap word input channel
interface mbb_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] bitmap_word;

    modport source (output valid, output bitmap_word, input ready);
    modport sink   (input valid, input bitmap_word, output ready);
endinterface

>>> hdl/mbb_pixel_if.sv
// pixel write output channel
interface mbb_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_address;
    logic [31:0] pixel_rgba;
    logic        last_of_word;

    modport source (output valid, output pixel_address, output pixel_rgba,
                    output last_of_word, input ready);
    modport sink   (input valid, input pixel_address, input pixel_rgba,
                    input last_of_word, output ready);
endinterface

>>> hdl/mono_bitmap_blit_clipped.sv
// monochrome bitmap blitter top level: clipping, pixel scan and address stepping
// the first pixel shows on the output in the cycle after the word's scan step reaches it
// a word is accepted, then scanned bit by bit up to its last visible pixel (at most 32 bits)
//   by the single bit scanner and its address incrementer, which takes no new word while it scans
// a word with no visible pixel is accepted without a scan; output stalls hold the scanner
// reset: asynchronous active low, clears control and configuration registers, position to
//   row 0 word 0; scan datapath registers are loaded before use
module mono_bitmap_blit_clipped (
    input  logic               clk,
    input  logic               rst_n,
    mbb_cfg_if.sink            cfg,
    mbb_word_if.sink           bitmap,
    mbb_pixel_if.source        pixel
);

    localparam int WB = mbb_pkg::WORD_BITS;

    mbb_pkg::blit_state_t state_reg, state_next;

    logic [11:0] origin_x_reg;
    logic [11:0] origin_y_reg;
    logic [10:0] rect_width_reg;
    logic [10:0] rect_height_reg;
    logic [31:0] draw_color_reg;
    logic        fill_mode_reg;
    logic [31:0] frame_base_reg;

    logic [10:0] row_index_reg, row_index_next;
    logic [4:0]  word_in_row_reg, word_in_row_next;

    logic [WB-1:0] mask_reg, mask_next;
    logic [31:0]   addr_reg, addr_next;
    logic [31:0]   rgba_reg;

    logic        out_valid_reg;
    logic [31:0] out_addr_reg;
    logic [31:0] out_rgba_reg;
    logic        out_last_reg;

    logic        accept;
    logic        step;
    logic        emit;
    logic [10:0] eff_w;
    logic [5:0]  wpr;
    logic        empty_rect;
    logic        stale;
    logic [10:0] eff_row;
    logic [4:0]  eff_word;
    logic [11:0] row_inc;
    logic [5:0]  word_inc;
    logic signed [12:0] py;
    logic        row_vis;
    logic signed [31:0] px0;
    logic signed [31:0] off;
    logic [WB-1:0] lane_mask;

    assign eff_w = (rect_width_reg > 11'(mbb_pkg::MAX_WIDTH)) ? 11'(mbb_pkg::MAX_WIDTH)
                                                            : rect_width_reg;
    assign wpr        = 6'((12'(eff_w) + 12'd31) >> 5);
    assign empty_rect = (eff_w == 11'd0) || (rect_height_reg == 11'd0);
    assign stale      = (row_index_reg >= rect_height_reg) || (6'(word_in_row_reg) >= wpr);
    assign eff_row    = stale ? 11'd0 : row_index_reg;
    assign eff_word   = stale ? 5'd0 : word_in_row_reg;

    assign py      = $signed({origin_y_reg[11], origin_y_reg}) + $signed({2'b00, eff_row});
    assign row_vis = (py >= 13'sd0) && (py < $signed(13'(mbb_pkg::SCREEN_HEIGHT)));

    // screen offset of the word's leftmost pixel; wraps like the address does
    assign px0 = $signed(32'({{20{origin_x_reg[11]}}, origin_x_reg}))
               + $signed(32'({eff_word, 5'b00000}));
    assign off = (32'(py) * 32'(mbb_pkg::LINE_STRIDE)) + px0;

    // visible pixel mask, bit 31 is the leftmost pixel
    always_comb
    begin
        logic [10:0]        col;
        logic signed [12:0] px;
        lane_mask = '0;
        for (int b = 0; b < WB; b++)
        begin
            col = {1'b0, eff_word, 5'(b)};
            px  = $signed({origin_x_reg[11], origin_x_reg}) + $signed({2'b00, col});
            lane_mask[WB-1-b] = (col < eff_w)
                              && (fill_mode_reg || bitmap.bitmap_word[WB-1-b])
                              && (px >= 13'sd0)
                              && (px < $signed(13'(mbb_pkg::SCREEN_WIDTH)));
        end
        if (!row_vis || empty_rect)
        begin
            lane_mask = '0;
        end
    end

    assign row_inc  = 12'(eff_row) + 12'd1;
    assign word_inc = 6'(eff_word) + 6'd1;

    always_comb
    begin
        if (empty_rect)
        begin
            row_index_next   = 11'd0;
            word_in_row_next = 5'd0;
        end
        else if (word_inc >= wpr)
        begin
            word_in_row_next = 5'd0;
            row_index_next   = (row_inc >= 12'(rect_height_reg)) ? 11'd0 : row_inc[10:0];
        end
        else
        begin
            word_in_row_next = word_inc[4:0];
            row_index_next   = eff_row;
        end
    end

    // sequencer: accept a word, then step one bit a cycle while the output is not stalled
    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        step       = 1'b0;
        mask_next  = mask_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            mbb_pkg::ST_IDLE:
            begin
                accept = bitmap.valid;
                if (accept)
                begin
                    mask_next = lane_mask;
                    addr_next = frame_base_reg + 32'(off <<< 2);
                    if (lane_mask != '0)
                    begin
                        state_next = mbb_pkg::ST_SCAN;
                    end
                end
            end
            mbb_pkg::ST_SCAN:
            begin
                step = !out_valid_reg || pixel.ready;
                if (step)
                begin
                    mask_next = {mask_reg[WB-2:0], 1'b0};
                    addr_next = addr_reg + 32'd4;
                    if (mask_reg[WB-2:0] == '0)
                    begin
                        state_next = mbb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = mbb_pkg::ST_IDLE;
            end
        endcase
    end

    assign emit = step && mask_reg[WB-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mbb_pkg::ST_IDLE;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            rect_width_reg  <= '0;
            rect_height_reg <= '0;
            draw_color_reg  <= '0;
            fill_mode_reg   <= 1'b0;
            frame_base_reg  <= '0;
            row_index_reg   <= '0;
            word_in_row_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    mbb_pkg::REG_ORIGIN_X:    origin_x_reg    <= cfg.data[11:0];
                    mbb_pkg::REG_ORIGIN_Y:    origin_y_reg    <= cfg.data[11:0];
                    mbb_pkg::REG_RECT_WIDTH:  rect_width_reg  <= cfg.data[10:0];
                    mbb_pkg::REG_RECT_HEIGHT: rect_height_reg <= cfg.data[10:0];
                    mbb_pkg::REG_DRAW_COLOR:  draw_color_reg  <= cfg.data;
                    mbb_pkg::REG_FILL_MODE:   fill_mode_reg   <= cfg.data[0];
                    mbb_pkg::REG_FRAME_BASE:  frame_base_reg  <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (accept)
            begin
                row_index_reg   <= row_index_next;
                word_in_row_reg <= word_in_row_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pixel.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        addr_reg <= addr_next;
        if (accept)
        begin
            rgba_reg <= mbb_pkg::color_to_rgba(draw_color_reg);
        end
        if (emit)
        begin
            out_addr_reg <= addr_reg;
            out_rgba_reg <= rgba_reg;
            out_last_reg <= (mask_reg[WB-2:0] == '0);
        end
    end

    assign cfg.ready           = 1'b1;
    assign bitmap.ready        = (state_reg == mbb_pkg::ST_IDLE);
    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_address = out_addr_reg;
    assign pixel.pixel_rgba    = out_rgba_reg;
    assign pixel.last_of_word  = out_last_reg;

endmodule

>>> tb/tb_mono_bitmap_blit_clipped.sv
`timescale 1ns / 100ps
// self-checking testbench for the monochrome bitmap blitter with predicted pixel writes
module tb_mono_bitmap_blit_clipped;

    localparam int WORD_TARGET   = 280;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [mbb_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] rgba;
        logic        last;
    } pixel_write_t;

    class blit_checker;
        logic [11:0]  origin_x;
        logic [11:0]  origin_y;
        logic [10:0]  rect_width;
        logic [10:0]  rect_height;
        logic [31:0]  draw_color;
        logic         fill_mode;
        logic [31:0]  frame_base;
        logic [10:0]  row_pos;
        logic [4:0]   word_pos;
        pixel_write_t pending_writes[$];
        int           mismatches;
        int           checked;

        function new();
            origin_x    = '0;
            origin_y    = '0;
            rect_width  = '0;
            rect_height = '0;
            draw_color  = '0;
            fill_mode   = 1'b0;
            frame_base  = '0;
            row_pos     = '0;
            word_pos    = '0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void write_register(logic [mbb_pkg::CFG_INDEX_W-1:0] idx,
                                     logic [31:0] data);
            case (idx)
                mbb_pkg::REG_ORIGIN_X:    origin_x    = data[11:0];
                mbb_pkg::REG_ORIGIN_Y:    origin_y    = data[11:0];
                mbb_pkg::REG_RECT_WIDTH:  rect_width  = data[10:0];
                mbb_pkg::REG_RECT_HEIGHT: rect_height = data[10:0];
                mbb_pkg::REG_DRAW_COLOR:  draw_color  = data;
                mbb_pkg::REG_FILL_MODE:   fill_mode   = data[0];
                mbb_pkg::REG_FRAME_BASE:  frame_base  = data;
                default: ;
            endcase
        endfunction

        function logic [31:0] widen_color(logic [31:0] v);
            logic [7:0] r;
            logic [7:0] g;
            logic [7:0] b;
            if (v <= 32'h0000_FFFF)
            begin
                r = (8'(v[15:11]) << 3) | 8'(v[15:13]);
                g = (8'(v[10:5]) << 2) | 8'(v[10:9]);
                b = (8'(v[4:0]) << 3) | 8'(v[4:2]);
            end
            else
            begin
                r = v[23:16];
                g = v[15:8];
                b = v[7:0];
            end
            return {8'hFF, b, g, r};
        endfunction

        // queue the pixel writes one bitmap word causes, then step the position
        function void expand_word(logic [31:0] word);
            int           w;
            int           h;
            int           wpr;
            int           col;
            int           py;
            int           px;
            int           offset;
            pixel_write_t held;
            bit           have_held;
            logic [31:0]  rgba;
            w = (rect_width > 11'd1024) ? mbb_pkg::MAX_WIDTH : int'(rect_width);
            h = int'(rect_height);
            wpr = (w + 31) / 32;
            if (w == 0 || h == 0)
            begin
                row_pos  = '0;
                word_pos = '0;
                return;
            end
            if (int'(row_pos) >= h || int'(word_pos) >= wpr)
            begin
                row_pos  = '0;
                word_pos = '0;
            end
            py = int'($signed(origin_y)) + int'(row_pos);
            have_held = 1'b0;
            if (py >= 0 && py < mbb_pkg::SCREEN_HEIGHT)
            begin
                rgba = widen_color(draw_color);
                for (int b = 0; b < mbb_pkg::WORD_BITS; b++)
                begin
                    col = int'(word_pos) * mbb_pkg::WORD_BITS + b;
                    if (col >= w)
                        break;
                    if (!fill_mode && !word[mbb_pkg::WORD_BITS - 1 - b])
                        continue;
                    px = int'($signed(origin_x)) + col;
                    if (px < 0 || px >= mbb_pkg::SCREEN_WIDTH)
                        continue;
                    if (have_held)
                        pending_writes.push_back(held);
                    offset       = py * mbb_pkg::LINE_STRIDE + px;
                    held.address = frame_base + (32'(offset) << 2);
                    held.rgba    = rgba;
                    held.last    = 1'b0;
                    have_held    = 1'b1;
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    pending_writes.push_back(held);
                end
            end
            if (int'(word_pos) + 1 >= wpr)
            begin
                word_pos = '0;
                if (int'(row_pos) + 1 >= h)
                    row_pos = '0;
                else
                    row_pos = row_pos + 1'b1;
            end
            else
                word_pos = word_pos + 1'b1;
        endfunction

        function void check_pixel(logic [31:0] address, logic [31:0] rgba, logic last);
            pixel_write_t want;
            checked++;
            if (pending_writes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected pixel write: addr %h rgba %h last %b",
                             address, rgba, last);
                return;
            end
            want = pending_writes.pop_front();
            if (want.address !== address || want.rgba !== rgba || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"pixel write mismatch: expected addr %h rgba %h last %b,",
                              " got addr %h rgba %h last %b"},
                             want.address, want.rgba, want.last, address, rgba, last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   words_sent;
    int   settings_used;
    int   cur_w;
    int   cur_h;
    bit   no_idle;

    blit_checker sb = new();

    mbb_cfg_if   cfg_ch();
    mbb_word_if  word_ch();
    mbb_pixel_if pix_ch();

    mono_bitmap_blit_clipped i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .bitmap (word_ch.sink),
        .pixel  (pix_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int idle_gap();
        return no_idle ? 0 : int'($urandom_range(0, 4));
    endfunction

    task automatic write_reg(input logic [mbb_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_register(idx, data);
        if (idx == mbb_pkg::REG_RECT_WIDTH)
            cur_w = int'(data[10:0]);
        if (idx == mbb_pkg::REG_RECT_HEIGHT)
            cur_h = int'(data[10:0]);
    endtask

    task automatic close_cfg();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic setup_all(input int ox, input int oy, input int w, input int h,
                             input logic [31:0] color, input bit fill,
                             input logic [31:0] base);
        write_reg(mbb_pkg::REG_ORIGIN_X, 32'(ox));
        write_reg(mbb_pkg::REG_ORIGIN_Y, 32'(oy));
        write_reg(mbb_pkg::REG_RECT_WIDTH, 32'(w));
        write_reg(mbb_pkg::REG_RECT_HEIGHT, 32'(h));
        write_reg(mbb_pkg::REG_DRAW_COLOR, color);
        write_reg(mbb_pkg::REG_FILL_MODE, 32'(fill));
        write_reg(mbb_pkg::REG_FRAME_BASE, base);
    endtask

    task automatic send_word(input logic [31:0] value);
        int gap;
        gap = idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        word_ch.valid       <= 1'b1;
        word_ch.bitmap_word <= value;
        do @(posedge clk); while (!word_ch.ready);
        sb.expand_word(value);
        words_sent++;
    endtask

    // hold off requests until every predicted pixel write is back
    task automatic drain();
        @(negedge clk);
        word_ch.valid <= 1'b0;
        while (sb.pending_writes.size() != 0)
            @(posedge clk);
    endtask

    // a word with no visible pixel gives no write to wait for, so drain and then give it time
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_origin(input int span);
        int v;
        case ($urandom_range(0, 9))
            0: v = -2048;
            1: v = 2047;
            2: v = span - 1;
            3: v = -31;
            default: v = int'($urandom_range(0, span + 40)) - 40;
        endcase
        return 32'(v);
    endfunction

    function automatic logic [31:0] pick_width();
        case ($urandom_range(0, 19))
            0: return 32'd0;
            1: return 32'd1024;
            2: return 32'($urandom_range(1025, 2047));
            3: return 32'd32;
            4: return 32'd1;
            default: return 32'($urandom_range(1, 96));
        endcase
    endfunction

    function automatic logic [31:0] pick_height(input int w);
        if (w >= mbb_pkg::MAX_WIDTH)
            return 32'($urandom_range(1, 2));
        case ($urandom_range(0, 19))
            0: return 32'd0;
            1: return 32'($urandom_range(1000, 2047));
            2: return 32'd1;
            default: return 32'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [31:0] pick_color();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h0000_FFFF;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom & 32'h0000_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase();
        int wpr;
        int total;
        int count;
        settle();
        no_idle = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0)
            write_reg(mbb_pkg::REG_ORIGIN_X, pick_origin(mbb_pkg::SCREEN_WIDTH));
        if ($urandom_range(0, 3) != 0)
            write_reg(mbb_pkg::REG_ORIGIN_Y, pick_origin(mbb_pkg::SCREEN_HEIGHT));
        if ($urandom_range(0, 3) != 0)
            write_reg(mbb_pkg::REG_RECT_WIDTH, ($urandom & 32'hFFFF_F800) | pick_width());
        if ($urandom_range(0, 3) != 0)
            write_reg(mbb_pkg::REG_RECT_HEIGHT,
                      ($urandom & 32'hFFFF_F800) | pick_height(cur_w));
        if ($urandom_range(0, 3) != 0)
            write_reg(mbb_pkg::REG_DRAW_COLOR, pick_color());
        if ($urandom_range(0, 3) != 0)
            write_reg(mbb_pkg::REG_FILL_MODE,
                      ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 3) == 0));
        if ($urandom_range(0, 3) != 0)
            write_reg(mbb_pkg::REG_FRAME_BASE,
                      ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom);
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, $urandom);
        close_cfg();
        wpr = ((cur_w > mbb_pkg::MAX_WIDTH ? mbb_pkg::MAX_WIDTH : cur_w) + 31) / 32;
        total = wpr * cur_h;
        if (total == 0)
            count = $urandom_range(1, 3);
        else if (total > 70 || $urandom_range(0, 4) == 0)
            count = $urandom_range(1, total > 40 ? 40 : total);
        else
            count = total;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 63) == 0)
                drain();
            send_word(pick_word());
        end
    endtask

    // result side: random stalls, every accepted write checked in order
    initial
    begin
        int stall;
        pix_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                pix_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            pix_ch.ready <= 1'b1;
            do @(posedge clk); while (!pix_ch.valid);
            sb.check_pixel(pix_ch.pixel_address, pix_ch.pixel_rgba, pix_ch.last_of_word);
        end
    end

    // watchdog on cycles with no request accepted anywhere
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((word_ch.valid && word_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no request accepted for %0d cycles, %0d writes outstanding",
                 QUIET_LIMIT, sb.pending_writes.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        word_ch.valid       = 1'b0;
        word_ch.bitmap_word = '0;
        words_sent          = 0;
        settings_used       = 0;
        cur_w               = 0;
        cur_h               = 0;
        no_idle             = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: zero size, words are consumed with no output
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0000);

        // two-word rows, bits past the width, unknown index must not disturb anything
        settle();
        setup_all(0, 0, 40, 2, 32'h0000_F81F, 1'b0, 32'h0000_1000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        close_cfg();
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0001);
        send_word(32'h0000_0001);

        // solid fill clipped left and below, address wraps past 2^32
        settle();
        setup_all(-5, 270, 33, 3, 32'h0012_3456, 1'b1, 32'hFFFF_FFF0);
        close_cfg();
        repeat (4) send_word($urandom);
        drain();
        send_word($urandom);

        // shrinking the height leaves the position stale, must restart at the top
        settle();
        write_reg(mbb_pkg::REG_RECT_HEIGHT, 32'd2);
        write_reg(mbb_pkg::REG_DRAW_COLOR, 32'h0000_FFFF);
        write_reg(mbb_pkg::REG_FILL_MODE, 32'd0);
        close_cfg();
        send_word(32'h5555_5555);
        send_word(32'hFFFF_FFFF);

        // origin extremes, fully off screen
        settle();
        setup_all(2047, -2048, 10, 1, 32'h0001_0000, 1'b0, 32'h0000_0000);
        close_cfg();
        send_word(32'hFFFF_FFFF);

        // last screen pixel only
        settle();
        setup_all(479, 271, 1, 1, 32'hFFFF_FFFF, 1'b0, 32'h7FFF_FFFC);
        close_cfg();
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFF);

        settle();
        setup_all(-2048, 2047, 5, 1, 32'h0000_0000, 1'b1, 32'h0000_0000);
        close_cfg();
        send_word(32'hFFFF_FFFF);

        // zero height
        settle();
        setup_all(0, 0, 32, 0, 32'h0000_07E0, 1'b1, 32'h0000_0000);
        close_cfg();
        send_word(32'hFFFF_FFFF);

        while (words_sent < WORD_TARGET)
            random_phase();

        settle();
        $display("covered %0d bitmap words under %0d register settings",
                 words_sent, settings_used);
        $display("%0d pixel writes checked, %0d bad or unexpected, %0d predicted writes missing",
                 sb.checked, sb.mismatches, sb.pending_writes.size());
        if (sb.mismatches == 0 && sb.pending_writes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
